// ===== rtl/core/mal_pkg.sv =====
// mal_pkg: shared widths, constants, status codes and control structs of
// the mesh airtime link metric core. No dependencies.
`default_nettype none

package mal_pkg;

    // field widths
    localparam int unsigned RATE_W  = 24;
    localparam int unsigned AIR_W   = 25;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned FA_W    = 7;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned RATEQ_W = 18;   // rate / 100 for a 24-bit rate

    // stream and register port widths
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned S_TUSER_W = 1;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned M_TUSER_W = 2;
    localparam int unsigned APB_DW    = 32;
    localparam int unsigned APB_AW    = 3;

    localparam logic [RATE_W-1:0] DEF_RATE_RST = 24'd1000;
    localparam logic [AIR_W-1:0]  AIR_MAX      = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

    // failure average: (80*f + 5) / 100 + 20 on failure, capped at 100
    localparam int unsigned FA_DECAY    = 80;
    localparam int unsigned FA_ROUND    = 5;
    localparam int unsigned FA_FAIL_ADD = 20;
    localparam int unsigned FA_MAX      = 100;
    localparam int unsigned FA_NUM_W    = 14;
    localparam int unsigned FA_PROD_W   = 27;
    localparam int unsigned FA_SUM_W    = 8;

    // divide by 100 as multiply by reciprocal and shift
    localparam int unsigned FA_RECIP      = 5243;
    localparam int unsigned FA_RECIP_SH   = 19;
    localparam int unsigned ERR_RECIP     = 671089;
    localparam int unsigned ERR_RECIP_W   = 20;
    localparam int unsigned ERR_RECIP_SH  = 26;
    localparam int unsigned RATE_RECIP    = 21474837;
    localparam int unsigned RATE_RECIP_W  = 25;
    localparam int unsigned RATE_RECIP_SH = 31;

    // metric scale constants
    localparam int unsigned METRIC_SCALE  = 10;
    localparam int unsigned BITS_PER_BYTE = 8;

    // status codes
    localparam logic [ST_W-1:0] ST_VALID     = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SUCC   = 2'd1;
    localparam logic [ST_W-1:0] ST_RATE_LOW  = 2'd2;
    localparam logic [ST_W-1:0] ST_FAIL_FULL = 2'd3;

    typedef enum logic {
        DIV_TX,
        DIV_RX
    } t_div_sel;

    typedef struct packed {
        logic     take;
        logic     update;
        logic     recip;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_tx;
        logic     cap_rx;
        logic     mul_lo;
        logic     mul_hi;
        logic     acc;
        logic     fin;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic special;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/mal_div.sv =====
// mal_div: restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by mal_dp.
`default_nettype none

module mal_div #(
    parameter int unsigned NW = 25,
    parameter int unsigned DW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic [NW-1:0]      o_quot
);

    localparam int unsigned CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;

    logic [DW:0]   shifted;
    logic          qbit;
    logic [DW:0]   diff;
    logic [DW-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_q[NW-1]};
        diff    = shifted - {1'b0, r_den};
        qbit    = (shifted >= {1'b0, r_den});
        n_rem   = qbit ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[NW-2:0], qbit};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/mal_ctrl.sv =====
// mal_ctrl: sequencer of the metric core; steps the datapath per item and
// owns the input ready and output valid. Depends on mal_pkg.
`default_nettype none

module mal_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire mal_pkg::t_stat i_stat,
    output mal_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MUL,
        S_CHK,
        S_DTX,
        S_DRX,
        S_MLO,
        S_MHI,
        S_MACC,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = mal_pkg::DIV_TX;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.recip = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_stat.special) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DTX;
                end
            end
            S_DTX: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_tx    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = mal_pkg::DIV_RX;
                    n_state         = S_DRX;
                end
            end
            S_DRX: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_rx = 1'b1;
                    n_state      = S_MLO;
                end
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MACC;
            end
            S_MACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DTX || r_state == S_DRX))
        else $error("divider done outside a wait state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready && r_state == S_DONE) |=> (r_state == S_DONE))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/core/mal_dp.sv =====
// mal_dp: link state, metric arithmetic and output register of the metric
// core. Depends on mal_pkg and mal_div.
`default_nettype none

module mal_dp #(
    parameter int unsigned FRAC_BITS        = 8,
    parameter int unsigned TEST_FRAME_BYTES = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mal_pkg::t_cmd               i_cmd,
    output mal_pkg::t_stat                   o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [mal_pkg::RATE_W-1:0]  i_cfg_rate,
    input  wire logic                        i_mode,
    input  wire logic                        i_is_data_frame,
    input  wire logic                        i_has_tx_status,
    input  wire logic                        i_tx_failed,
    input  wire logic [mal_pkg::RATE_W-1:0]  i_tx_rate,
    output logic [mal_pkg::AIR_W-1:0]        o_airtime,
    output logic [mal_pkg::ST_W-1:0]         o_status
);

    localparam int unsigned F          = FRAC_BITS;
    localparam logic [63:0] SUNIT      = 64'd1 << F;
    localparam logic [63:0] TX_NUM     =
        64'(mal_pkg::METRIC_SCALE * mal_pkg::BITS_PER_BYTE * TEST_FRAME_BYTES) << F;
    localparam logic [63:0] RX_NUM     = 64'd1 << (2 * F);
    localparam int unsigned TXQ_W      = $clog2(TX_NUM + 64'd1);
    localparam int unsigned RX_W       = 2 * F + 1;
    localparam int unsigned NW         = (TXQ_W > RX_W) ? TXQ_W : RX_W;
    localparam int unsigned ERR_W      = F + 1;
    localparam int unsigned DW         = (mal_pkg::RATEQ_W > ERR_W) ? mal_pkg::RATEQ_W : ERR_W;
    localparam int unsigned TXT_W      = TXQ_W + 1;
    localparam int unsigned H          = (TXT_W + 1) / 2;
    localparam int unsigned PART_W     = H + RX_W;
    localparam int unsigned PROD_W     = TXT_W + RX_W;
    localparam int unsigned ERR_IN_W   = mal_pkg::FA_W + F;
    localparam int unsigned ERR_PROD_W = ERR_IN_W + mal_pkg::ERR_RECIP_W;
    localparam int unsigned RATE_PROD_W = mal_pkg::RATE_W + mal_pkg::RATE_RECIP_W;

    // captured item
    logic                        r_mode;
    logic                        r_is_data;
    logic                        r_has_st;
    logic                        r_failed;
    logic [mal_pkg::RATE_W-1:0]  r_rate;

    // link state
    logic [mal_pkg::FA_W-1:0]    r_fa;
    logic [mal_pkg::RATE_W-1:0]  r_last;
    logic [mal_pkg::CNT_W-1:0]   r_count;

    // metric work registers
    logic [mal_pkg::RATEQ_W-1:0] r_rate_q;
    logic [ERR_W-1:0]            r_err;
    logic [TXT_W-1:0]            r_tx_time;
    logic [RX_W-1:0]             r_retx;
    logic [PART_W-1:0]           r_part;
    logic [PROD_W-1:0]           r_acc;
    logic [mal_pkg::AIR_W-1:0]   r_res_air;
    logic [mal_pkg::ST_W-1:0]    r_res_st;
    logic [mal_pkg::AIR_W-1:0]   r_out_air;
    logic [mal_pkg::ST_W-1:0]    r_out_st;

    logic [mal_pkg::FA_NUM_W-1:0]  fa_num;
    logic [mal_pkg::FA_PROD_W-1:0] fa_prod;
    logic [mal_pkg::FA_SUM_W-1:0]  fa_sum;
    logic [mal_pkg::FA_W-1:0]      fa_next;
    logic [ERR_PROD_W-1:0]         err_prod;
    logic [RATE_PROD_W-1:0]        rate_prod;
    logic                          no_succ;
    logic                          rate_low;
    logic                          fail_full;
    logic [PROD_W-1:0]             prod_sh;
    logic [NW-1:0]                 div_num;
    logic [DW-1:0]                 div_den;
    logic                          div_busy;
    logic                          div_done;
    logic [NW-1:0]                 div_q;

    always_comb begin
        fa_num  = mal_pkg::FA_NUM_W'(mal_pkg::FA_DECAY) * mal_pkg::FA_NUM_W'(r_fa)
                + mal_pkg::FA_NUM_W'(mal_pkg::FA_ROUND);
        fa_prod = mal_pkg::FA_PROD_W'(fa_num) * mal_pkg::FA_PROD_W'(mal_pkg::FA_RECIP);
        fa_sum  = mal_pkg::FA_SUM_W'(fa_prod >> mal_pkg::FA_RECIP_SH)
                + (r_failed ? mal_pkg::FA_SUM_W'(mal_pkg::FA_FAIL_ADD) : '0);
        fa_next = (fa_sum > mal_pkg::FA_SUM_W'(mal_pkg::FA_MAX))
                ? mal_pkg::FA_W'(mal_pkg::FA_MAX) : fa_sum[mal_pkg::FA_W-1:0];
    end

    assign err_prod  = ERR_PROD_W'({r_fa, {F{1'b0}}}) * ERR_PROD_W'(mal_pkg::ERR_RECIP);
    assign rate_prod = RATE_PROD_W'(r_last) * RATE_PROD_W'(mal_pkg::RATE_RECIP);

    assign no_succ   = (r_count == '0);
    assign rate_low  = (r_rate_q == '0);
    assign fail_full = (r_err >= ERR_W'(SUNIT));
    assign prod_sh   = r_acc >> (2 * F);

    assign div_num = (i_cmd.div_sel == mal_pkg::DIV_TX) ? NW'(TX_NUM) : NW'(RX_NUM);
    assign div_den = (i_cmd.div_sel == mal_pkg::DIV_TX) ? DW'(r_rate_q)
                                                        : DW'(ERR_W'(SUNIT) - r_err);

    mal_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa    <= '0;
            r_last  <= mal_pkg::DEF_RATE_RST;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_last <= i_cfg_rate;
        end else if (i_cmd.update) begin
            if (r_mode) begin
                r_count <= '0;
            end else if (r_is_data && r_has_st) begin
                if (!r_failed) begin
                    r_last <= r_rate;
                    if (r_count != mal_pkg::CNT_MAX) r_count <= r_count + mal_pkg::CNT_W'(1);
                end
                r_fa <= fa_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode    <= i_mode;
            r_is_data <= i_is_data_frame;
            r_has_st  <= i_has_tx_status;
            r_failed  <= i_tx_failed;
            r_rate    <= i_tx_rate;
        end
        if (i_cmd.recip) begin
            r_rate_q <= mal_pkg::RATEQ_W'(rate_prod >> mal_pkg::RATE_RECIP_SH);
            r_err    <= ERR_W'(err_prod >> mal_pkg::ERR_RECIP_SH);
        end
        if (i_cmd.cap_tx) r_tx_time <= TXT_W'(SUNIT) + TXT_W'(div_q[TXQ_W-1:0]);
        if (i_cmd.cap_rx) r_retx <= div_q[RX_W-1:0];
        if (i_cmd.mul_lo) r_part <= PART_W'(r_tx_time[H-1:0]) * PART_W'(r_retx);
        if (i_cmd.mul_hi) begin
            r_acc  <= PROD_W'(r_part);
            r_part <= PART_W'(r_tx_time[TXT_W-1:H]) * PART_W'(r_retx);
        end
        if (i_cmd.acc) r_acc <= r_acc + (PROD_W'(r_part) << H);
        if (i_cmd.fin) begin
            if (no_succ) begin
                r_res_air <= '0;
                r_res_st  <= mal_pkg::ST_NO_SUCC;
            end else if (rate_low) begin
                r_res_air <= mal_pkg::AIR_MAX;
                r_res_st  <= mal_pkg::ST_RATE_LOW;
            end else if (fail_full) begin
                r_res_air <= mal_pkg::AIR_MAX;
                r_res_st  <= mal_pkg::ST_FAIL_FULL;
            end else begin
                r_res_air <= (prod_sh > PROD_W'(mal_pkg::AIR_MAX))
                           ? mal_pkg::AIR_MAX : prod_sh[mal_pkg::AIR_W-1:0];
                r_res_st  <= mal_pkg::ST_VALID;
            end
        end
        if (i_cmd.load_out) begin
            r_out_air <= r_res_air;
            r_out_st  <= r_res_st;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.special  = no_succ || rate_low || fail_full;
    assign o_airtime       = r_out_air;
    assign o_status        = r_out_st;

    a_fa_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fa <= mal_pkg::FA_W'(mal_pkg::FA_MAX))
        else $error("failure average above cap");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_mode && !i_cfg_we) |=> (r_count == '0))
        else $error("window clear did not reset success count");

endmodule

`default_nettype wire

// ===== rtl/core/mesh_airtime_link_metric_core.sv =====
// mesh_airtime_link_metric_core: top level of the airtime link metric core.
// Depends on mal_pkg, mal_ctrl, mal_dp (and mal_div below it).
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata, tuser
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata, tuser
//  apb       in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item at a time. A counted item runs both divisions of the metric,
// one after the other, on the shared bit-serial divider, whose dividend
// width NW is 25 at the default parameters. Items that hit a special
// case skip the divisions. Reset is synchronous and needs no clearing
// pass. The output register lets the next beat in while a result waits;
// a stalled result holds the sequencer before its next load.
`default_nettype none

module mesh_airtime_link_metric_core #(
    parameter int unsigned FRAC_BITS        = 8,
    parameter int unsigned TEST_FRAME_BYTES = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mal_pkg::APB_AW-1:0]      paddr,
    input  wire logic [mal_pkg::APB_DW-1:0]      pwdata,
    output logic      [mal_pkg::APB_DW-1:0]      prdata,
    output logic                                 pready,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] is_data_frame, [1] has_tx_status, [2] tx_failed, [26:3] tx_rate
    input  wire logic [mal_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] mode
    input  wire logic [mal_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [24:0] airtime
    output logic      [mal_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic      [mal_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int unsigned RW = mal_pkg::RATE_W;

    logic [RW-1:0]             r_def_rate;
    logic                      cfg_sel;
    logic                      cfg_we;
    mal_pkg::t_cmd             cmd;
    mal_pkg::t_stat            stat;
    logic [mal_pkg::AIR_W-1:0] airtime;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? mal_pkg::APB_DW'(r_def_rate) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_rate <= mal_pkg::DEF_RATE_RST;
        end else if (cfg_we) begin
            r_def_rate <= pwdata[RW-1:0];
        end
    end

    mal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mal_dp #(
        .FRAC_BITS        (FRAC_BITS),
        .TEST_FRAME_BYTES (TEST_FRAME_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (cfg_we),
        .i_cfg_rate      (pwdata[RW-1:0]),
        .i_mode          (s_axis_tuser[0]),
        .i_is_data_frame (s_axis_tdata[0]),
        .i_has_tx_status (s_axis_tdata[1]),
        .i_tx_failed     (s_axis_tdata[2]),
        .i_tx_rate       (s_axis_tdata[RW+2:3]),
        .o_airtime       (airtime),
        .o_status        (m_axis_tuser)
    );

    assign m_axis_tdata = mal_pkg::M_TDATA_W'(airtime);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking testbench for mesh_airtime_link_metric_core. It runs directed and
// random transmit reports against a cycle-free metric predictor under three stall profiles.
// Depends on mal_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned FRAC        = 8;
    localparam int unsigned FRAME_BYTES = 1024;
    localparam int unsigned RUN_LIMIT   = 600000;
    localparam int unsigned DRAIN_WAIT  = 100;

    localparam logic [mal_pkg::APB_AW-1:0] REG_DEFAULT_RATE = '0;
    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic                       is_data;
        logic                       has_st;
        logic                       failed;
        logic [mal_pkg::RATE_W-1:0] rate;
    } t_tx_report;

    typedef struct packed {
        logic [mal_pkg::AIR_W-1:0] airtime;
        logic [mal_pkg::ST_W-1:0]  status;
    } t_metric;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [mal_pkg::APB_AW-1:0]    paddr         = '0;
    logic [mal_pkg::APB_DW-1:0]    pwdata        = '0;
    logic [mal_pkg::APB_DW-1:0]    prdata;
    logic                          pready;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mal_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [mal_pkg::S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mal_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [mal_pkg::M_TUSER_W-1:0] m_axis_tuser;

    // predictor state
    logic [mal_pkg::RATE_W-1:0] mdl_default_rate;
    logic [mal_pkg::RATE_W-1:0] mdl_last_rate;
    logic [mal_pkg::FA_W-1:0]   mdl_fail_avg;
    logic [mal_pkg::CNT_W-1:0]  mdl_succ_cnt;

    t_metric     pending_metrics[$];
    t_metric     want_metric;
    int unsigned src_idle_pct  = 27;
    int unsigned snk_idle_pct  = 55;
    int unsigned cycle_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes    = 0;
    int unsigned mismatches    = 0;
    int unsigned directed_beats;

    mesh_airtime_link_metric_core #(
        .FRAC_BITS        (FRAC),
        .TEST_FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [0] is_data_frame, [1] has_tx_status, [2] tx_failed, [26:3] tx_rate
        .s_axis_tdata  (s_axis_tdata),
        // [0] mode
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [24:0] airtime
        .m_axis_tdata  (m_axis_tdata),
        // [1:0] status
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_metrics.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic t_metric current_metric();
        logic [63:0] rate_q;
        logic [63:0] err;
        logic [63:0] unit_q;
        logic [63:0] tx_t;
        logic [63:0] retx;
        logic [63:0] prod;
        t_metric     m;
        unit_q = 64'd1 << FRAC;
        rate_q = 64'(mdl_last_rate) / 100;
        err    = (64'(mdl_fail_avg) << FRAC) / 100;
        if (mdl_succ_cnt == '0) begin
            m.airtime = '0;
            m.status  = mal_pkg::ST_NO_SUCC;
        end else if (rate_q == 0) begin
            m.airtime = mal_pkg::AIR_MAX;
            m.status  = mal_pkg::ST_RATE_LOW;
        end else if (err >= unit_q) begin
            m.airtime = mal_pkg::AIR_MAX;
            m.status  = mal_pkg::ST_FAIL_FULL;
        end else begin
            tx_t = unit_q + (64'(mal_pkg::METRIC_SCALE)
                   * (64'(mal_pkg::BITS_PER_BYTE * FRAME_BYTES) << FRAC)) / rate_q;
            retx = (64'd1 << (2 * FRAC)) / (unit_q - err);
            prod = (tx_t * retx) >> (2 * FRAC);
            m.airtime = (prod > 64'(mal_pkg::AIR_MAX))
                      ? mal_pkg::AIR_MAX : prod[mal_pkg::AIR_W-1:0];
            m.status  = mal_pkg::ST_VALID;
        end
        return m;
    endfunction

    function automatic t_metric predict_report(input t_tx_report r);
        int unsigned fa_next;
        if (r.mode == MODE_CLEAR) begin
            mdl_succ_cnt = '0;
        end else if (r.is_data && r.has_st) begin
            if (!r.failed) begin
                mdl_last_rate = r.rate;
                if (mdl_succ_cnt != mal_pkg::CNT_MAX)
                    mdl_succ_cnt = mdl_succ_cnt + mal_pkg::CNT_W'(1);
            end
            fa_next = (mal_pkg::FA_DECAY * mdl_fail_avg + mal_pkg::FA_ROUND) / mal_pkg::FA_MAX
                      + (r.failed ? mal_pkg::FA_FAIL_ADD : 0);
            if (fa_next > mal_pkg::FA_MAX)
                fa_next = mal_pkg::FA_MAX;
            mdl_fail_avg = fa_next[mal_pkg::FA_W-1:0];
        end
        return current_metric();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at cycle %0d: expected 0x%0h, got 0x%0h",
                     what, cycle_count, exp_v, act_v);
    endtask

    // outputs are stable at the falling edge, so a beat seen here completes at the next rise
    always @(negedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_checked++;
            if (pending_metrics.size() == 0) begin
                report_mismatch("unexpected beat", '0, m_axis_tdata);
            end else begin
                want_metric = pending_metrics.pop_front();
                if (m_axis_tdata !== mal_pkg::M_TDATA_W'(want_metric.airtime))
                    report_mismatch("airtime", 32'(want_metric.airtime), m_axis_tdata);
                if (m_axis_tuser !== want_metric.status)
                    report_mismatch("status", 32'(want_metric.status), 32'(m_axis_tuser));
            end
        end
    end

    task automatic send_report(input t_tx_report r);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom();
            s_axis_tuser  <= mal_pkg::S_TUSER_W'($urandom_range(1));
            @(posedge i_clk);
        end
        s_axis_tdata  <= {5'b0, r.rate, r.failed, r.has_st, r.is_data};
        s_axis_tuser  <= r.mode;
        s_axis_tvalid <= 1'b1;
        pending_metrics.push_back(predict_report(r));
        beats_sent++;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic send_fields(input logic mode, input logic is_data, input logic has_st,
                               input logic failed, input logic [mal_pkg::RATE_W-1:0] rate);
        t_tx_report r;
        r = '{mode: mode, is_data: is_data, has_st: has_st, failed: failed, rate: rate};
        send_report(r);
    endtask

    task automatic drain_results(input int unsigned extra_cycles);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_metrics.size() != 0);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic write_default_rate(input logic [mal_pkg::APB_DW-1:0] wdata);
        drain_results(DRAIN_WAIT);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DEFAULT_RATE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom();
        mdl_default_rate = wdata[mal_pkg::RATE_W-1:0];
        mdl_last_rate    = mdl_default_rate;
        reg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [mal_pkg::RATE_W-1:0] random_rate();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return mal_pkg::RATE_W'($urandom_range(600000, 6000));
        else if (sel < 75)
            return mal_pkg::RATE_W'($urandom_range(199));
        else if (sel < 90)
            return mal_pkg::RATE_W'($urandom());
        else if (sel < 95)
            return mal_pkg::RATE_W'(10000000);
        else
            return '1;
    endfunction

    function automatic t_tx_report random_report(input int unsigned fail_pct);
        t_tx_report  r;
        int unsigned pick;
        logic [1:0]  flags;
        pick      = $urandom_range(99);
        r.mode    = MODE_REPORT;
        r.is_data = 1'b1;
        r.has_st  = 1'b1;
        r.failed  = ($urandom_range(99) < fail_pct);
        r.rate    = random_rate();
        if (pick < 5) begin
            r.mode    = MODE_CLEAR;
            r.is_data = 1'($urandom_range(1));
            r.has_st  = 1'($urandom_range(1));
        end else if (pick < 15) begin
            // at least one of the two qualifiers is low
            flags     = 2'($urandom_range(2));
            r.is_data = flags[1];
            r.has_st  = flags[0];
        end
        return r;
    endfunction

    task automatic test_after_reset();
        send_fields(MODE_REPORT, 1'b0, 1'b1, 1'b0, '1);
        send_fields(MODE_CLEAR, 1'b1, 1'b1, 1'b1, '1);
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b1, '0);
    endtask

    task automatic test_rate_edges();
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(0));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(99));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(100));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(10000000));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, '1);
    endtask

    task automatic test_report_filter();
        send_fields(MODE_REPORT, 1'b1, 1'b0, 1'b0, mal_pkg::RATE_W'(5000));
        send_fields(MODE_REPORT, 1'b0, 1'b1, 1'b0, mal_pkg::RATE_W'(50));
        send_fields(MODE_REPORT, 1'b0, 1'b0, 1'b1, mal_pkg::RATE_W'(0));
    endtask

    task automatic test_failure_buildup();
        repeat (6)
            send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b1, mal_pkg::RATE_W'($urandom()));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(100));
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(54000));
    endtask

    task automatic test_window_clear();
        send_fields(MODE_CLEAR, 1'b0, 1'b0, 1'b0, '0);
        send_fields(MODE_REPORT, 1'b1, 1'b0, 1'b1, '1);
        send_fields(MODE_REPORT, 1'b1, 1'b1, 1'b0, mal_pkg::RATE_W'(24'h800000));
    endtask

    // a write reloads the last rate; the success count is kept
    task automatic test_default_rate_reg();
        write_default_rate(32'd50);
        send_fields(MODE_REPORT, 1'b0, 1'b0, 1'b0, '0);
        write_default_rate(32'hFFFF_FFFF);
        send_fields(MODE_REPORT, 1'b0, 1'b1, 1'b1, '0);
        write_default_rate(32'd0);
        send_fields(MODE_REPORT, 1'b1, 1'b0, 1'b0, '1);
        write_default_rate(32'd10000000);
        send_fields(MODE_REPORT, 1'b0, 1'b1, 1'b0, '0);
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned src_pct,
                                       input int unsigned snk_pct);
        int unsigned fail_pct;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        fail_pct     = 30;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0: fail_pct = 5;
                    1: fail_pct = 30;
                    default: fail_pct = 90;
                endcase
            end
            if (i == n_items / 2)
                drain_results(0);
            send_report(random_report(fail_pct));
        end
    endtask

    initial begin
        mdl_default_rate = mal_pkg::DEF_RATE_RST;
        mdl_last_rate    = mal_pkg::DEF_RATE_RST;
        mdl_fail_avg     = '0;
        mdl_succ_cnt     = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_rate_edges();
        test_report_filter();
        test_failure_buildup();
        test_window_clear();
        test_default_rate_reg();
        directed_beats = beats_sent;

        write_default_rate($urandom());
        test_random_traffic(200, 27, 55);
        write_default_rate({8'($urandom_range(255)),
                            mal_pkg::RATE_W'($urandom_range(10000000, 100))});
        test_random_traffic(200, 55, 27);
        write_default_rate(32'd100);
        test_random_traffic(200, 0, 0);
        drain_results(DRAIN_WAIT);

        if (pending_metrics.size() != 0)
            report_mismatch("missing results", 32'(pending_metrics.size()), '0);
        $display("%0d report/clear beats (%0d directed), %0d rate register writes,",
                 beats_sent, directed_beats, reg_writes);
        $display("%0d result beats checked over three stall profiles, %0d mismatches",
                 beats_checked, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mal_pkg.sv
rtl/core/mal_div.sv
rtl/core/mal_ctrl.sv
rtl/core/mal_dp.sv
rtl/core/mesh_airtime_link_metric_core.sv
sim/tb_top.sv
